// ===== hw/rtl/mclbp_pkg.sv =====
// shared types and constants for the multi-channel led blink / pulse unit
// no dependencies; imported by the top level, the checker and the bench
package mclbp_pkg;

  localparam int CHANNELS  = 4;
  localparam int TIME_BITS = 32;
  localparam int OUT_BITS  = 4;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 2;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_SLOW  = 3'd2,
    MODE_FAST  = 3'd3,
    MODE_PULSE = 3'd4
  } led_mode_t;

  localparam logic FUNC_SET    = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam logic [IDX_BITS-1:0] REG_SLOW_INTERVAL = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_FAST_INTERVAL = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_PULSE_WIDTH   = 2'd2;

  localparam logic [CFG_BITS-1:0] SLOW_INTERVAL_RESET = 16'd500;
  localparam logic [CFG_BITS-1:0] FAST_INTERVAL_RESET = 16'd150;
  localparam logic [CFG_BITS-1:0] PULSE_WIDTH_RESET   = 16'd50;

  typedef struct packed {
    logic        func;
    logic [1:0]  channel;
    logic [2:0]  led_mode;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [3:0] led_levels;
    logic [3:0] pulse_busy;
  } res_t;

endpackage

// ===== hw/rtl/multi_channel_led_blink_pulse_unit.sv =====
// path: a request is held in the input register, then its result in the result register
// throughput: one request per cycle while no result is stalled, set by the per-channel
// compare logic; a stalled result holds the input register and the channel state as well
// reset: rst is synchronous; all channels off with leds low, intervals 500/150/50 ms
// file: top level of the led blink / pulse unit, depends on mclbp_pkg
module multi_channel_led_blink_pulse_unit
  import mclbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  req_t                req_data,
  output logic                res_valid,
  input  logic                res_stall,
  output res_t                res_data,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic [CFG_BITS-1:0] slow_interval_ms;
  logic [CFG_BITS-1:0] fast_interval_ms;
  logic [CFG_BITS-1:0] pulse_width_ms;

  logic [2:0]           requested_mode   [CHANNELS];
  logic [2:0]           applied_mode     [CHANNELS];
  logic                 pulse_running    [CHANNELS];
  logic [TIME_BITS-1:0] pulse_start_time [CHANNELS];
  logic [TIME_BITS-1:0] last_toggle_time [CHANNELS];
  logic                 led_level        [CHANNELS];

  logic [2:0]           requested_mode_next   [CHANNELS];
  logic [2:0]           applied_mode_next     [CHANNELS];
  logic                 pulse_running_next    [CHANNELS];
  logic [TIME_BITS-1:0] pulse_start_time_next [CHANNELS];
  logic [TIME_BITS-1:0] last_toggle_time_next [CHANNELS];
  logic                 led_level_next        [CHANNELS];

  logic  held_valid;
  req_t  held;
  logic  go;
  res_t  res_next;

  assign go        = held_valid && (!res_valid || !res_stall);
  assign req_stall = held_valid && !go;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_interval_ms <= SLOW_INTERVAL_RESET;
      fast_interval_ms <= FAST_INTERVAL_RESET;
      pulse_width_ms   <= PULSE_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOW_INTERVAL: slow_interval_ms <= cfg_data;
        REG_FAST_INTERVAL: fast_interval_ms <= cfg_data;
        REG_PULSE_WIDTH:   pulse_width_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (go || !held_valid) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      held <= req_data;
    end
  end

  // per-channel service, all channels side by side
  always_comb begin
    logic [TIME_BITS-1:0] now;
    logic [2:0]           req;
    logic [TIME_BITS-1:0] interval;
    logic                 set_ok;

    now      = TIME_BITS'(held.now_ms);
    req      = MODE_OFF;
    interval = '0;
    set_ok   = (held.led_mode <= MODE_PULSE) && ({30'd0, held.channel} < CHANNELS);
    for (int c = 0; c < CHANNELS; c++) begin
      requested_mode_next[c]   = requested_mode[c];
      applied_mode_next[c]     = applied_mode[c];
      pulse_running_next[c]    = pulse_running[c];
      pulse_start_time_next[c] = pulse_start_time[c];
      last_toggle_time_next[c] = last_toggle_time[c];
      led_level_next[c]        = led_level[c];

      if (held.func == FUNC_SET) begin
        if (set_ok && (32'(held.channel) == 32'(c))) begin
          requested_mode_next[c] = held.led_mode;
        end
      end else begin
        // pending pulse is consumed first
        if (requested_mode[c] == MODE_PULSE) begin
          requested_mode_next[c]   = MODE_OFF;
          pulse_running_next[c]    = 1'b1;
          pulse_start_time_next[c] = now;
          led_level_next[c]        = 1'b1;
        end
        req = requested_mode_next[c];

        if (pulse_running_next[c]) begin
          if ((now - pulse_start_time_next[c]) >= TIME_BITS'(pulse_width_ms)) begin
            pulse_running_next[c] = 1'b0;
            led_level_next[c]     = 1'b0;
          end
        end else begin
          if (req != applied_mode[c]) begin
            applied_mode_next[c]     = req;
            last_toggle_time_next[c] = now;
            if (req == MODE_OFF) begin
              led_level_next[c] = 1'b0;
            end else if (req == MODE_ON) begin
              led_level_next[c] = 1'b1;
            end
          end
          case (req)
            MODE_SLOW: interval = TIME_BITS'(slow_interval_ms);
            MODE_FAST: interval = TIME_BITS'(fast_interval_ms);
            default:   interval = '0;
          endcase
          if ((interval != '0) && ((now - last_toggle_time_next[c]) >= interval)) begin
            led_level_next[c]        = !led_level_next[c];
            last_toggle_time_next[c] = now;
          end
        end
      end
    end

    res_next = '0;
    for (int i = 0; i < OUT_BITS; i++) begin
      if (i < CHANNELS) begin
        res_next.led_levels[i] = led_level_next[i];
        res_next.pulse_busy[i] = pulse_running_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        requested_mode[c]   <= MODE_OFF;
        applied_mode[c]     <= MODE_OFF;
        pulse_running[c]    <= 1'b0;
        pulse_start_time[c] <= '0;
        last_toggle_time[c] <= '0;
        led_level[c]        <= 1'b0;
      end
    end else if (go) begin
      for (int c = 0; c < CHANNELS; c++) begin
        requested_mode[c]   <= requested_mode_next[c];
        applied_mode[c]     <= applied_mode_next[c];
        pulse_running[c]    <= pulse_running_next[c];
        pulse_start_time[c] <= pulse_start_time_next[c];
        last_toggle_time[c] <= last_toggle_time_next[c];
        led_level[c]        <= led_level_next[c];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_data <= res_next;
    end
  end

endmodule

// ===== hw/rtl/mclbp_checker.sv =====
// port-level checks for the led blink / pulse unit, bound to the top level
// depends on mclbp_pkg
module mclbp_checker
  import mclbp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res_data
);

  // no result straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("stalled result dropped");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res_data))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (res_valid && res_stall))
    else $error("request stalled with result side free");

  // a running pulse always holds its led high
  a_busy_led: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_data.pulse_busy & ~res_data.led_levels) == 4'd0))
    else $error("pulse busy with led low");

endmodule

bind multi_channel_led_blink_pulse_unit mclbp_checker u_mclbp_checker (.*);

// ===== test/multi_channel_led_blink_pulse_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for the multi-channel led blink / pulse unit: random and directed
// requests, register writes between phases, per-request prediction of levels and busy bits
// depends on mclbp_pkg and multi_channel_led_blink_pulse_unit
module multi_channel_led_blink_pulse_unit_tb
  import mclbp_pkg::*;
;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam logic [2:0] MODE_BAD_FIRST = 3'd5;
  localparam logic [2:0] MODE_BAD_LAST  = 3'd7;
  localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

  class led_scoreboard;
    led_mode_t          requested [CHANNELS];
    led_mode_t          applied   [CHANNELS];
    bit                 pulsing   [CHANNELS];
    bit [TIME_BITS-1:0] pulse_from[CHANNELS];
    bit [TIME_BITS-1:0] toggled_at[CHANNELS];
    bit                 lit       [CHANNELS];
    bit [CFG_BITS-1:0]  slow_ms;
    bit [CFG_BITS-1:0]  fast_ms;
    bit [CFG_BITS-1:0]  width_ms;
    res_t               levels_q[$];
    int                 mismatches;

    function new();
      slow_ms    = SLOW_INTERVAL_RESET;
      fast_ms    = FAST_INTERVAL_RESET;
      width_ms   = PULSE_WIDTH_RESET;
      mismatches = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        requested[c]  = MODE_OFF;
        applied[c]    = MODE_OFF;
        pulsing[c]    = 1'b0;
        pulse_from[c] = '0;
        toggled_at[c] = '0;
        lit[c]        = 1'b0;
      end
    endfunction

    function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_SLOW_INTERVAL: slow_ms = val;
        REG_FAST_INTERVAL: fast_ms = val;
        REG_PULSE_WIDTH:   width_ms = val;
        default: ;
      endcase
    endfunction

    function void service(int c, bit [TIME_BITS-1:0] now);
      bit [CFG_BITS-1:0]  interval;
      bit [TIME_BITS-1:0] since;
      if (requested[c] == MODE_PULSE) begin
        requested[c]  = MODE_OFF;
        pulsing[c]    = 1'b1;
        pulse_from[c] = now;
        lit[c]        = 1'b1;
      end
      // a running pulse masks any mode change until it has expired
      if (pulsing[c]) begin
        since = now - pulse_from[c];
        if (since >= width_ms) begin
          pulsing[c] = 1'b0;
          lit[c]     = 1'b0;
        end
        return;
      end
      if (requested[c] != applied[c]) begin
        applied[c]    = requested[c];
        toggled_at[c] = now;
        if (requested[c] == MODE_OFF)
          lit[c] = 1'b0;
        else if (requested[c] == MODE_ON)
          lit[c] = 1'b1;
      end
      case (requested[c])
        MODE_SLOW: interval = slow_ms;
        MODE_FAST: interval = fast_ms;
        default:   interval = '0;
      endcase
      since = now - toggled_at[c];
      if (interval != 0 && since >= interval) begin
        lit[c]        = !lit[c];
        toggled_at[c] = now;
      end
    endfunction

    function void note_request(req_t r);
      res_t want;
      if (r.func == FUNC_SET) begin
        if (r.channel < CHANNELS && r.led_mode <= MODE_PULSE)
          requested[r.channel] = led_mode_t'(r.led_mode);
      end else begin
        for (int c = 0; c < CHANNELS; c++)
          service(c, r.now_ms);
      end
      want = '0;
      for (int c = 0; c < CHANNELS && c < OUT_BITS; c++) begin
        want.led_levels[c] = lit[c];
        want.pulse_busy[c] = pulsing[c];
      end
      levels_q.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (levels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding, levels %b busy %b",
                   $time, got.led_levels, got.pulse_busy);
        return;
      end
      want = levels_q.pop_front();
      if (got.led_levels !== want.led_levels || got.pulse_busy !== want.pulse_busy) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: levels exp %b got %b, busy exp %b got %b", $time,
                   want.led_levels, got.led_levels, want.pulse_busy, got.pulse_busy);
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req_data  = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  res_t                res_data;
  logic                cfg_we    = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  led_scoreboard      sb = new();
  int unsigned        cycles     = 0;
  int                 hold_trig  = 0;
  int                 hold_seen  = 0;
  int                 hold_left  = 0;
  bit                 rx_idle_on = 1'b1;
  bit                 tx_idle_on = 1'b1;
  bit [TIME_BITS-1:0] clock_ms   = '0;

  multi_channel_led_blink_pulse_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("multi_channel_led_blink_pulse_unit verification failed");
      $finish;
    end
  end

  // result side: check, then pick the next stall, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result(res_data);
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= rx_idle_on && ($urandom_range(99) < 20);
    end
  end

  function automatic req_t request_of(logic func, logic [1:0] ch, logic [2:0] mode,
                                      logic [TIME_BITS-1:0] t);
    req_t r;
    r.func     = func;
    r.channel  = ch;
    r.led_mode = mode;
    r.now_ms   = t;
    return r;
  endfunction

  task automatic send(input req_t r);
    while (tx_idle_on && $urandom_range(99) < 20) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.levels_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic poke_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_BITS-1:0] slow, fast, width);
    drain();
    poke_reg(REG_SLOW_INTERVAL, slow);
    poke_reg(REG_FAST_INTERVAL, fast);
    poke_reg(REG_PULSE_WIDTH, width);
    // index past the register list must leave everything untouched
    poke_reg(REG_UNUSED, CFG_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  // mostly updates on a creeping clock, some mode sets, a few time jumps
  task automatic run_random(input int count, input int unsigned step_max);
    req_t r;
    int   roll;
    repeat (count) begin
      roll       = $urandom_range(99);
      r.func     = FUNC_UPDATE;
      r.channel  = 2'($urandom);
      r.led_mode = 3'($urandom);
      r.now_ms   = $urandom;
      if (roll < 30) begin
        r.func = FUNC_SET;
        if ($urandom_range(9) != 0)
          r.led_mode = 3'($urandom_range(MODE_PULSE, MODE_OFF));
      end else if (roll < 96) begin
        clock_ms += $urandom_range(step_max);
        r.now_ms  = clock_ms;
      end else begin
        clock_ms = r.now_ms;
      end
      send(r);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'd0));
    send(request_of(FUNC_SET, 2'd0, MODE_ON, 32'd0));
    send(request_of(FUNC_SET, 2'd1, MODE_SLOW, 32'd0));
    send(request_of(FUNC_SET, 2'd2, MODE_FAST, 32'd0));
    send(request_of(FUNC_SET, 2'd3, MODE_PULSE, 32'd0));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'd10));
    send(request_of(FUNC_SET, 2'd3, MODE_ON, 32'd0));
    send(request_of(FUNC_SET, 2'd0, MODE_BAD_FIRST, 32'd0));
    send(request_of(FUNC_SET, 2'd1, MODE_BAD_LAST, 32'hFFFF_FFFF));
    send(request_of(FUNC_UPDATE, 2'd3, MODE_BAD_LAST, 32'd40));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'd60));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'd200));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'd700));
    send(request_of(FUNC_SET, 2'd2, MODE_PULSE, 32'd0));
    send(request_of(FUNC_SET, 2'd1, MODE_OFF, 32'd0));
    // pulse straddling the wrap of the millisecond counter
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'hFFFF_FFE0));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'h0000_0030));
    send(request_of(FUNC_SET, 2'd0, MODE_SLOW, 32'hFFFF_FFFF));
    send(request_of(FUNC_UPDATE, 2'd3, MODE_PULSE, 32'hFFFF_FFFF));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'h0000_01F3));
    send(request_of(FUNC_SET, 2'd3, MODE_OFF, 32'd0));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, 32'h0000_0400));

    clock_ms = 32'd1000;
    run_random(200, 300);

    // result side holds off while requests keep coming, so the input backs up
    tx_idle_on = 1'b0;
    hold_trig <= hold_trig + 1;
    run_random(60, 300);
    tx_idle_on = 1'b1;
    drain();

    configure(16'd1, 16'd1, 16'd1);
    run_random(200, 4);

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    run_random(200, 50000);

    // zero intervals never toggle, zero width ends the pulse in the same update
    configure(16'd0, 16'd0, 16'd0);
    send(request_of(FUNC_SET, 2'd2, MODE_PULSE, 32'd0));
    send(request_of(FUNC_UPDATE, 2'd0, MODE_OFF, clock_ms));
    run_random(150, 20);

    // back to back on both sides
    configure(CFG_BITS'($urandom_range(40, 2)), CFG_BITS'($urandom_range(40, 2)),
              CFG_BITS'($urandom_range(40, 2)));
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    run_random(200, 80);
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;

    configure(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom));
    run_random(200, 70000);

    configure(SLOW_INTERVAL_RESET, FAST_INTERVAL_RESET, PULSE_WIDTH_RESET);
    clock_ms = 32'hFFFF_FE00;
    run_random(100, 200);

    drain();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.levels_q.size() == 0)
      $display("multi_channel_led_blink_pulse_unit verification clean");
    else
      $display("multi_channel_led_blink_pulse_unit verification failed");
    $finish;
  end

endmodule
